// ===== sv/segment_circle_steer_check_assert.svh =====
`ifndef SEGMENT_CIRCLE_STEER_CHECK_ASSERT_SVH
`define SEGMENT_CIRCLE_STEER_CHECK_ASSERT_SVH
// same-cycle implication, checked outside reset
`define SCC_ASSERT_NOW(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("scc check failed");
// next-cycle implication, checked outside reset
`define SCC_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("scc check failed");
`endif

// ===== sv/scc_pkg.sv =====
package scc_pkg;

   localparam int MAX_OBSTACLES = 16;
   localparam int FRAC_BITS     = 8;
   localparam int COORD_W       = 24;
   localparam int RAD_W         = 23;
   localparam int DIFF_W        = COORD_W + 1;
   localparam int MUL_W         = 2 * DIFF_W;
   localparam int PROD_W        = 2 * MUL_W;
   localparam int C_W           = MUL_W + 2;
   localparam int P_W           = MUL_W + 1;
   localparam int E_W           = MUL_W + 3;
   localparam int REM_W         = MUL_W + 3;
   localparam int T_FRAC        = 16;
   localparam int T_W           = T_FRAC + 1;
   localparam int RND_W         = DIFF_W + T_W + 2;
   localparam int IDX_W         = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
   localparam int CNT_W         = $clog2(MAX_OBSTACLES + 1);
   localparam int STEP_W        = $clog2(MUL_W + 1);
   localparam int SQRT_STEPS    = MUL_W;

   localparam logic [COORD_W-1:0] FAIL_COORD = COORD_W'(-(1 <<< FRAC_BITS));
   localparam logic [MUL_W-1:0]   SHORT_LIM  = MUL_W'(1) << (2 * FRAC_BITS);
   localparam logic [T_W-1:0]     T_ONE      = T_W'(1) << T_FRAC;

   typedef enum logic [1:0] {
      REQ_ADD   = 2'd0,
      REQ_STEER = 2'd1,
      REQ_CHECK = 2'd2
   } kind_type;

   typedef struct packed {
      logic [1:0]                req_type;
      logic signed [COORD_W-1:0] ax;
      logic signed [COORD_W-1:0] ay;
      logic signed [COORD_W-1:0] bx;
      logic signed [COORD_W-1:0] by;
      logic [RAD_W-1:0]          radius;
   } req_item_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] new_x;
      logic signed [COORD_W-1:0] new_y;
      logic                      steer_failed;
      logic                      path_blocked;
      logic                      table_full;
   } rsp_item_type;

   typedef enum logic [4:0] {
      S_IDLE, S_LOAD, S_ADD, S_DX2, S_DY2, S_SHORT, S_LOOP, S_FETCH,
      S_FX2, S_FY2, S_R2, S_CTEST, S_PX, S_PY, S_PTEST, S_NP2, S_AC,
      S_DTEST, S_SQRT_INIT, S_SQRT, S_DIV_INIT, S_DIV, S_TMIN, S_NEXT,
      S_TX, S_TY, S_RESULT
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_LOAD, OP_ADD, OP_LOOP_INIT, OP_FETCH, OP_CAPT,
      OP_SET_INSIDE, OP_SQ_INIT, OP_SQ_STEP, OP_DIV_INIT, OP_DIV_STEP,
      OP_TMIN, OP_NEXT, OP_RESULT
   } op_type;

   typedef enum logic [3:0] {
      M_DX2, M_DY2, M_FX2, M_FY2, M_R2, M_PX, M_PY, M_NP2, M_AC, M_TX, M_TY
   } msel_type;

   typedef struct packed {
      op_type   op;
      msel_type msel;
      logic     mul_start;
   } cmd_type;

   typedef struct packed {
      logic is_add;
      logic is_steer;
      logic is_check;
      logic is_short;
      logic c_le0;
      logic p_ge0;
      logic no_hit;
      logic idx_end;
      logic in_circle;
      logic mul_done;
      logic rsp_free;
   } sts_type;

endpackage

// ===== sv/segment_circle_steer_check.sv =====
// add item: load, add, then result state; unknown request type: load, then result state
// check and steer: squared length, then per stored obstacle up to 7 products of the
// shared 50-step serial multiplier, a 50-step square root and a 17-step divide;
// the result state waits for a free result register; one item in flight at a time
// reset clears the controller, the obstacle count and the result valid;
// obstacle table contents stay undefined until written
module segment_circle_steer_check import scc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_data
);

   cmd_type cmd;
   sts_type sts;

   scc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .sts       (sts),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   scc_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== sv/scc_mul.sv =====
module scc_mul import scc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [MUL_W-1:0]  op_a,
   input  logic [MUL_W-1:0]  op_b,
   output logic              done,
   output logic [PROD_W-1:0] prod
);

   logic              busy_ff;
   logic              done_ff;
   logic [STEP_W-1:0] cnt_ff;
   logic [PROD_W-1:0] acc_ff;
   logic [PROD_W-1:0] mcand_ff;
   logic [MUL_W-1:0]  mplier_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= !start && busy_ff && cnt_ff == STEP_W'(MUL_W - 1);
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == STEP_W'(MUL_W - 1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // one multiplier bit per cycle, shift and add
   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff    <= '0;
         mcand_ff  <= PROD_W'(op_a);
         mplier_ff <= op_b;
         cnt_ff    <= '0;
      end else if (busy_ff) begin
         if (mplier_ff[0]) begin
            acc_ff <= acc_ff + mcand_ff;
         end
         mcand_ff  <= mcand_ff << 1;
         mplier_ff <= mplier_ff >> 1;
         cnt_ff    <= cnt_ff + STEP_W'(1);
      end
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule

// ===== sv/scc_datapath.sv =====
module scc_datapath import scc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cmd_type      cmd,
   input  req_item_type req_data,
   input  logic         rsp_stall,
   output sts_type      sts,
   output logic         rsp_valid,
   output rsp_item_type rsp_data
);

   function automatic logic [DIFF_W-1:0] mag(input logic signed [DIFF_W-1:0] v);
      return v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
   endfunction

   logic [1:0]                kind_ff;
   logic signed [COORD_W-1:0] ax_ff, ay_ff;
   logic [RAD_W-1:0]          radius_ff;
   logic signed [DIFF_W-1:0]  dx_ff, dy_ff, fx_ff, fy_ff;
   logic [RAD_W-1:0]          r_ff;
   logic [MUL_W-1:0]          a_ff;
   logic [CNT_W-1:0]          count_ff, idx_ff;
   logic signed [C_W-1:0]     c_ff;
   logic signed [P_W-1:0]     p_ff;
   logic [PROD_W-1:0]         np2_ff, ac_ff, rad_ff;
   logic [REM_W-1:0]          srem_ff;
   logic [MUL_W-1:0]          root_ff;
   logic [MUL_W:0]            drem_ff;
   logic [T_W-1:0]            q_ff, tmin_ff;
   logic [COORD_W-1:0]        nx_ff, ny_ff;
   logic                      short_ff, inside_ff, hit_ff, full_ff;
   logic                      rsp_valid_ff;
   rsp_item_type              rsp_ff;
   rsp_item_type              rsp_in;

   logic signed [COORD_W-1:0] cx_mem [MAX_OBSTACLES];
   logic signed [COORD_W-1:0] cy_mem [MAX_OBSTACLES];
   logic [RAD_W-1:0]          r_mem  [MAX_OBSTACLES];

   logic [MUL_W-1:0]          mul_a, mul_b;
   logic                      mul_done;
   logic [PROD_W-1:0]         prod;
   logic                      prod_neg;
   logic signed [P_W-1:0]     pterm;
   logic signed [RND_W-1:0]   rterm, rsum;
   logic [COORD_W-1:0]        rstep;
   logic [MUL_W-1:0]          np;
   logic [PROD_W-1:0]         disc;
   logic signed [E_W-1:0]     e_val;
   logic [REM_W-1:0]          rem_sh, trial;
   logic [MUL_W:0]            dsh, d0, a_ext;
   logic [T_W-1:0]            q_sat;
   logic                      full_now;

   scc_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (cmd.mul_start),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .done  (mul_done),
      .prod  (prod)
   );

   always_comb begin
      mul_a    = '0;
      mul_b    = '0;
      prod_neg = 1'b0;
      case (cmd.msel)
         M_DX2:   begin mul_a = MUL_W'(mag(dx_ff)); mul_b = MUL_W'(mag(dx_ff)); end
         M_DY2:   begin mul_a = MUL_W'(mag(dy_ff)); mul_b = MUL_W'(mag(dy_ff)); end
         M_FX2:   begin mul_a = MUL_W'(mag(fx_ff)); mul_b = MUL_W'(mag(fx_ff)); end
         M_FY2:   begin mul_a = MUL_W'(mag(fy_ff)); mul_b = MUL_W'(mag(fy_ff)); end
         M_R2:    begin mul_a = MUL_W'(r_ff); mul_b = MUL_W'(r_ff); end
         M_PX: begin
            mul_a    = MUL_W'(mag(fx_ff));
            mul_b    = MUL_W'(mag(dx_ff));
            prod_neg = fx_ff[DIFF_W-1] ^ dx_ff[DIFF_W-1];
         end
         M_PY: begin
            mul_a    = MUL_W'(mag(fy_ff));
            mul_b    = MUL_W'(mag(dy_ff));
            prod_neg = fy_ff[DIFF_W-1] ^ dy_ff[DIFF_W-1];
         end
         M_NP2:   begin mul_a = np; mul_b = np; end
         M_AC:    begin mul_a = a_ff; mul_b = c_ff[MUL_W-1:0]; end
         M_TX: begin
            mul_a    = MUL_W'(mag(dx_ff));
            mul_b    = MUL_W'(tmin_ff);
            prod_neg = dx_ff[DIFF_W-1];
         end
         M_TY: begin
            mul_a    = MUL_W'(mag(dy_ff));
            mul_b    = MUL_W'(tmin_ff);
            prod_neg = dy_ff[DIFF_W-1];
         end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   always_comb begin
      pterm  = signed'({1'b0, prod[MUL_W-1:0]});
      if (prod_neg) pterm = -pterm;
      rterm  = signed'({1'b0, prod[RND_W-2:0]});
      if (prod_neg) rterm = -rterm;
      // round half up, then floor by the arithmetic shift
      rsum   = (rterm + RND_W'(1 <<< (T_FRAC - 1))) >>> T_FRAC;
      rstep  = rsum[COORD_W-1:0];
      np     = MUL_W'(-p_ff);
      disc   = np2_ff - ac_ff;
      e_val  = (E_W'(p_ff) <<< 1) + signed'({3'b000, a_ff}) + E_W'(c_ff);
      rem_sh = {srem_ff[REM_W-3:0], rad_ff[PROD_W-1 -: 2]};
      trial  = {1'b0, root_ff, 2'b01};
      a_ext  = {1'b0, a_ff};
      dsh    = {drem_ff[MUL_W-1:0], 1'b0};
      d0     = {1'b0, np - root_ff};
      q_sat  = (q_ff > T_ONE) ? T_ONE : q_ff;
      full_now = count_ff >= CNT_W'(MAX_OBSTACLES);
   end

   always_comb begin
      rsp_in = '0;
      case (kind_ff)
         REQ_ADD: rsp_in.table_full = full_ff;
         REQ_STEER: begin
            if (short_ff || inside_ff) begin
               rsp_in.steer_failed = 1'b1;
               rsp_in.new_x        = FAIL_COORD;
               rsp_in.new_y        = FAIL_COORD;
            end else begin
               rsp_in.new_x = nx_ff;
               rsp_in.new_y = ny_ff;
            end
         end
         REQ_CHECK: rsp_in.path_blocked = !short_ff && (inside_ff || hit_ff);
         default:   rsp_in.table_full   = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.op == OP_ADD && !full_now) begin
            count_ff <= count_ff + CNT_W'(1);
         end
         if (cmd.op == OP_RESULT) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            kind_ff   <= req_data.req_type;
            ax_ff     <= req_data.ax;
            ay_ff     <= req_data.ay;
            radius_ff <= req_data.radius;
            dx_ff     <= DIFF_W'(req_data.bx) - DIFF_W'(req_data.ax);
            dy_ff     <= DIFF_W'(req_data.by) - DIFF_W'(req_data.ay);
         end
         OP_ADD: begin
            full_ff <= full_now;
            if (!full_now) begin
               cx_mem[count_ff[IDX_W-1:0]] <= ax_ff;
               cy_mem[count_ff[IDX_W-1:0]] <= ay_ff;
               r_mem[count_ff[IDX_W-1:0]]  <= radius_ff;
            end
         end
         OP_LOOP_INIT: begin
            idx_ff    <= '0;
            inside_ff <= 1'b0;
            hit_ff    <= 1'b0;
            tmin_ff   <= T_ONE;
            short_ff  <= a_ff <= SHORT_LIM;
         end
         OP_FETCH: begin
            fx_ff <= DIFF_W'(ax_ff) - DIFF_W'(cx_mem[idx_ff[IDX_W-1:0]]);
            fy_ff <= DIFF_W'(ay_ff) - DIFF_W'(cy_mem[idx_ff[IDX_W-1:0]]);
            r_ff  <= r_mem[idx_ff[IDX_W-1:0]];
         end
         OP_CAPT: begin
            case (cmd.msel)
               M_DX2:   a_ff   <= prod[MUL_W-1:0];
               M_DY2:   a_ff   <= a_ff + prod[MUL_W-1:0];
               M_FX2:   c_ff   <= signed'({2'b00, prod[MUL_W-1:0]});
               M_FY2:   c_ff   <= c_ff + signed'({2'b00, prod[MUL_W-1:0]});
               M_R2:    c_ff   <= c_ff - signed'({2'b00, prod[MUL_W-1:0]});
               M_PX:    p_ff   <= pterm;
               M_PY:    p_ff   <= p_ff + pterm;
               M_NP2:   np2_ff <= prod;
               M_AC:    ac_ff  <= prod;
               M_TX:    nx_ff  <= ax_ff + rstep;
               M_TY:    ny_ff  <= ay_ff + rstep;
               default: a_ff   <= a_ff;
            endcase
         end
         OP_SET_INSIDE: inside_ff <= 1'b1;
         OP_SQ_INIT: begin
            rad_ff  <= disc;
            srem_ff <= '0;
            root_ff <= '0;
         end
         OP_SQ_STEP: begin
            rad_ff <= rad_ff << 2;
            if (rem_sh >= trial) begin
               srem_ff <= rem_sh - trial;
               root_ff <= {root_ff[MUL_W-2:0], 1'b1};
            end else begin
               srem_ff <= rem_sh;
               root_ff <= {root_ff[MUL_W-2:0], 1'b0};
            end
         end
         OP_DIV_INIT: begin
            if (d0 >= a_ext) begin
               drem_ff <= d0 - a_ext;
               q_ff    <= T_W'(1);
            end else begin
               drem_ff <= d0;
               q_ff    <= '0;
            end
         end
         OP_DIV_STEP: begin
            if (dsh >= a_ext) begin
               drem_ff <= dsh - a_ext;
               q_ff    <= {q_ff[T_W-2:0], 1'b1};
            end else begin
               drem_ff <= dsh;
               q_ff    <= {q_ff[T_W-2:0], 1'b0};
            end
         end
         OP_TMIN: begin
            hit_ff <= 1'b1;
            if (q_sat < tmin_ff) tmin_ff <= q_sat;
         end
         OP_NEXT:   idx_ff <= idx_ff + CNT_W'(1);
         OP_RESULT: rsp_ff <= rsp_in;
         default:   idx_ff <= idx_ff;
      endcase
   end

   always_comb begin
      sts.is_add    = kind_ff == REQ_ADD;
      sts.is_steer  = kind_ff == REQ_STEER;
      sts.is_check  = kind_ff == REQ_CHECK;
      sts.is_short  = a_ff <= SHORT_LIM;
      sts.c_le0     = c_ff <= 0;
      sts.p_ge0     = !p_ff[P_W-1];
      // tangent or entry beyond the end point counts as a miss
      sts.no_hit    = (np2_ff <= ac_ff) || !((np < a_ff) || (e_val < 0));
      sts.idx_end   = idx_ff == count_ff;
      sts.in_circle = inside_ff;
      sts.mul_done  = mul_done;
      sts.rsp_free  = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== sv/scc_ctrl.sv =====
module scc_ctrl import scc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  sts_type sts,
   output logic    req_stall,
   output cmd_type cmd
);

   state_type         state_ff, state_in;
   logic              launched_ff, launched_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              is_mul;
   msel_type          msel;
   state_type         after_mul;

   // which product each multiply state forms and where it goes next
   always_comb begin
      is_mul    = 1'b1;
      msel      = M_DX2;
      after_mul = S_IDLE;
      case (state_ff)
         S_DX2:   begin msel = M_DX2; after_mul = S_DY2;   end
         S_DY2:   begin msel = M_DY2; after_mul = S_SHORT; end
         S_FX2:   begin msel = M_FX2; after_mul = S_FY2;   end
         S_FY2:   begin msel = M_FY2; after_mul = S_R2;    end
         S_R2:    begin msel = M_R2;  after_mul = S_CTEST; end
         S_PX:    begin msel = M_PX;  after_mul = S_PY;    end
         S_PY:    begin msel = M_PY;  after_mul = S_PTEST; end
         S_NP2:   begin msel = M_NP2; after_mul = S_AC;    end
         S_AC:    begin msel = M_AC;  after_mul = S_DTEST; end
         S_TX:    begin msel = M_TX;  after_mul = S_TY;    end
         S_TY:    begin msel = M_TY;  after_mul = S_RESULT; end
         default: is_mul = 1'b0;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         S_IDLE: if (req_valid) state_in = S_LOAD;
         S_LOAD: begin
            if (sts.is_add) state_in = S_ADD;
            else if (sts.is_steer || sts.is_check) state_in = S_DX2;
            else state_in = S_RESULT;
         end
         S_ADD:   state_in = S_RESULT;
         S_SHORT: state_in = sts.is_short ? S_RESULT : S_LOOP;
         S_LOOP: begin
            if (!sts.idx_end) state_in = S_FETCH;
            else if (sts.is_steer && !sts.in_circle) state_in = S_TX;
            else state_in = S_RESULT;
         end
         S_FETCH:     state_in = S_FX2;
         S_CTEST:     state_in = sts.c_le0 ? S_NEXT : S_PX;
         S_PTEST:     state_in = sts.p_ge0 ? S_NEXT : S_NP2;
         S_DTEST:     state_in = sts.no_hit ? S_NEXT : S_SQRT_INIT;
         S_SQRT_INIT: begin
            state_in = S_SQRT;
            cnt_in   = '0;
         end
         S_SQRT: begin
            if (cnt_ff == STEP_W'(SQRT_STEPS - 1)) state_in = S_DIV_INIT;
            cnt_in = cnt_ff + STEP_W'(1);
         end
         S_DIV_INIT: begin
            state_in = S_DIV;
            cnt_in   = '0;
         end
         S_DIV: begin
            if (cnt_ff == STEP_W'(T_FRAC - 1)) state_in = S_TMIN;
            cnt_in = cnt_ff + STEP_W'(1);
         end
         S_TMIN:   state_in = S_NEXT;
         S_NEXT:   state_in = S_LOOP;
         S_RESULT: if (sts.rsp_free) state_in = S_IDLE;
         default: begin
            if (is_mul && launched_ff && sts.mul_done) state_in = after_mul;
         end
      endcase
   end

   always_comb begin
      cmd.op        = OP_NONE;
      cmd.msel      = msel;
      cmd.mul_start = 1'b0;
      req_stall     = 1'b1;
      launched_in   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) cmd.op = OP_LOAD;
         end
         S_ADD:       cmd.op = OP_ADD;
         S_SHORT:     cmd.op = OP_LOOP_INIT;
         S_FETCH:     cmd.op = OP_FETCH;
         S_CTEST:     if (sts.c_le0) cmd.op = OP_SET_INSIDE;
         S_SQRT_INIT: cmd.op = OP_SQ_INIT;
         S_SQRT:      cmd.op = OP_SQ_STEP;
         S_DIV_INIT:  cmd.op = OP_DIV_INIT;
         S_DIV:       cmd.op = OP_DIV_STEP;
         S_TMIN:      cmd.op = OP_TMIN;
         S_NEXT:      cmd.op = OP_NEXT;
         S_RESULT:    if (sts.rsp_free) cmd.op = OP_RESULT;
         default: begin
            if (is_mul) begin
               if (!launched_ff) begin
                  cmd.mul_start = 1'b1;
                  launched_in   = 1'b1;
               end else if (sts.mul_done) begin
                  cmd.op = OP_CAPT;
               end else begin
                  launched_in = 1'b1;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         launched_ff <= 1'b0;
         cnt_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         launched_ff <= launched_in;
         cnt_ff      <= cnt_in;
      end
   end

endmodule

// ===== sv/scc_checker.sv =====
`include "segment_circle_steer_check_assert.svh"
module scc_checker import scc_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_item_type rsp_data
);

   logic [2:0] flag_bits;
   logic       fail_point;
   logic       zero_point;

   assign flag_bits  = {rsp_data.steer_failed, rsp_data.path_blocked, rsp_data.table_full};
   assign fail_point = rsp_data.new_x == FAIL_COORD && rsp_data.new_y == FAIL_COORD;
   assign zero_point = rsp_data.new_x == '0 && rsp_data.new_y == '0;

   `SCC_ASSERT_NEXT(a_req_busy, req_valid && !req_stall, req_stall)
   `SCC_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
   `SCC_ASSERT_NOW(a_one_flag, rsp_valid, $countones(flag_bits) <= 1)
   `SCC_ASSERT_NOW(a_fail_point, rsp_valid && rsp_data.steer_failed, fail_point)
   `SCC_ASSERT_NOW(a_flag_no_point, rsp_valid && (flag_bits[1] || flag_bits[0]), zero_point)

endmodule

bind segment_circle_steer_check scc_checker u_scc_checker (.*);

// ===== dv/segment_circle_steer_check_test.sv =====
`timescale 1ns / 1ps

module segment_circle_steer_check_test;
   import scc_pkg::*;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_item_type req_data;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_item_type rsp_data;

   segment_circle_steer_check uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   // model copy of the obstacle table
   longint       circ_x[MAX_OBSTACLES];
   longint       circ_y[MAX_OBSTACLES];
   longint       circ_r[MAX_OBSTACLES];
   int           circ_count;

   rsp_item_type pending_rsp[$];
   int           error_count;
   bit           no_idle;
   int           rsp_hold;

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   function automatic int draw_gap();
      return no_idle ? 0 : $urandom_range(0, 6);
   endfunction

   // 0 no contact, 1 start inside, 2 entered at tq (unsigned Q1.16)
   function automatic int probe_circle(longint sx, longint sy, longint dx, longint dy,
                                       longint a, int i, output longint unsigned tq);
      longint fx, fy, c, p, e;
      logic [127:0] np2, ac, disc, sq;
      longint unsigned np, s, cand, rem, q, ua;
      fx = sx - circ_x[i];
      fy = sy - circ_y[i];
      c = fx * fx + fy * fy - circ_r[i] * circ_r[i];
      tq = 0;
      if (c <= 0) return 1;
      p = fx * dx + fy * dy;
      if (p >= 0) return 0;
      np = -p;
      np2 = 128'(np) * 128'(np);
      ac = 128'(a) * 128'(c);
      if (np2 <= ac) return 0;
      e = 2 * p + a + c;
      if (!(longint'(np) < a || e < 0)) return 0;
      disc = np2 - ac;
      s = 0;
      for (int k = 49; k >= 0; k--) begin
         cand = s | (64'd1 << k);
         sq = 128'(cand) * 128'(cand);
         if (sq <= disc) s = cand;
      end
      ua = a;
      rem = np - s;
      q = 0;
      if (rem >= ua) begin
         q = 1;
         rem -= ua;
      end
      for (int k = 0; k < T_FRAC; k++) begin
         rem = rem << 1;
         q = q << 1;
         if (rem >= ua) begin
            q |= 1;
            rem -= ua;
         end
      end
      if (q > (64'd1 << T_FRAC)) q = 64'd1 << T_FRAC;
      tq = q;
      return 2;
   endfunction

   function automatic longint scaled_step(longint d, longint unsigned t);
      longint v;
      v = d * longint'(t) + (64'sd1 <<< (T_FRAC - 1));
      return v >>> T_FRAC;
   endfunction

   function automatic rsp_item_type steer_outcome(req_item_type it);
      rsp_item_type r;
      longint ax, ay, dx, dy, a;
      longint unsigned tmin, tq;
      bit shrt, start_in, hit;
      int res;
      r = '0;
      ax = longint'($signed(it.ax));
      ay = longint'($signed(it.ay));
      dx = longint'($signed(it.bx)) - ax;
      dy = longint'($signed(it.by)) - ay;
      case (it.req_type)
         REQ_ADD: begin
            if (circ_count >= MAX_OBSTACLES) begin
               r.table_full = 1'b1;
            end else begin
               circ_x[circ_count] = ax;
               circ_y[circ_count] = ay;
               circ_r[circ_count] = longint'(it.radius);
               circ_count++;
            end
         end
         REQ_STEER, REQ_CHECK: begin
            a = dx * dx + dy * dy;
            shrt = a <= (64'sd1 <<< (2 * FRAC_BITS));
            start_in = 0;
            hit = 0;
            tmin = 64'd1 << T_FRAC;
            if (!shrt) begin
               for (int i = 0; i < circ_count; i++) begin
                  res = probe_circle(ax, ay, dx, dy, a, i, tq);
                  if (res == 1) start_in = 1;
                  else if (res == 2) begin
                     hit = 1;
                     if (tq < tmin) tmin = tq;
                  end
               end
            end
            if (it.req_type == REQ_STEER) begin
               if (shrt || start_in) begin
                  r.steer_failed = 1'b1;
                  r.new_x = FAIL_COORD;
                  r.new_y = FAIL_COORD;
               end else begin
                  r.new_x = COORD_W'(ax + scaled_step(dx, tmin));
                  r.new_y = COORD_W'(ay + scaled_step(dy, tmin));
               end
            end else begin
               r.path_blocked = !shrt && (start_in || hit);
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
      error_count++;
   endtask

   task automatic send_item(input req_item_type it);
      int gap;
      gap = draw_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data <= it;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      pending_rsp = {pending_rsp, steer_outcome(it)};
   endtask

   task automatic send_fields(input kind_type kind, input int ax, input int ay,
                              input int bx, input int by, input int rad);
      req_item_type it;
      it.req_type = kind;
      it.ax = COORD_W'(ax);
      it.ay = COORD_W'(ay);
      it.bx = COORD_W'(bx);
      it.by = COORD_W'(by);
      it.radius = RAD_W'(rad);
      send_item(it);
   endtask

   // result side: stall for a drawn number of cycles after each item
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_stall <= 1'b1;
         rsp_hold <= rsp_hold - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_hold <= draw_gap();
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected item", 32'(rsp_data), 0);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.new_x !== want.new_x)
               report_mismatch("new_x", 32'(rsp_data.new_x), 32'(want.new_x));
            if (rsp_data.new_y !== want.new_y)
               report_mismatch("new_y", 32'(rsp_data.new_y), 32'(want.new_y));
            if (rsp_data.steer_failed !== want.steer_failed)
               report_mismatch("steer_failed", 32'(rsp_data.steer_failed),
                               32'(want.steer_failed));
            if (rsp_data.path_blocked !== want.path_blocked)
               report_mismatch("path_blocked", 32'(rsp_data.path_blocked),
                               32'(want.path_blocked));
            if (rsp_data.table_full !== want.table_full)
               report_mismatch("table_full", 32'(rsp_data.table_full),
                               32'(want.table_full));
         end
      end
   end

   task automatic test_empty_table();
      send_fields(REQ_STEER, 0, 0, 1000, -500, 0);
      send_fields(REQ_CHECK, 0, 0, 1000, -500, 0);
      // exactly one unit long counts as too short
      send_fields(REQ_STEER, 0, 0, 256, 0, 0);
      send_fields(REQ_CHECK, 100, 100, 100, 356, 0);
      send_fields(REQ_STEER, -8388608, 8388607, 8388607, -8388608, 0);
      send_fields(REQ_CHECK, 8388607, -8388608, -8388608, 8388607, 8388607);
   endtask

   task automatic test_unknown_type();
      req_item_type it;
      it = '1;
      send_item(it);
   endtask

   task automatic test_circle_cases();
      send_fields(REQ_ADD, 0, 0, 8388607, -8388608, 512);
      // tangent line does not count
      send_fields(REQ_CHECK, -2048, 512, 2048, 512, 0);
      send_fields(REQ_STEER, -2048, 512, 2048, 512, 0);
      // touch right at the end point does not count
      send_fields(REQ_CHECK, -2048, 0, -512, 0, 0);
      send_fields(REQ_STEER, -2048, 0, -512, 0, 0);
      send_fields(REQ_STEER, -2048, 0, 2048, 0, 0);
      send_fields(REQ_CHECK, -2048, 0, 2048, 0, 0);
      send_fields(REQ_STEER, 0, 0, 2048, 300, 0);
      send_fields(REQ_CHECK, 0, 0, 2048, 300, 0);
      // start on the rim is inside
      send_fields(REQ_STEER, 512, 0, 2048, 0, 0);
      send_fields(REQ_STEER, 2048, 2048, -2048, -1900, 0);
      send_fields(REQ_ADD, 3000, 0, 0, 0, 0);
      send_fields(REQ_ADD, -8388608, -8388608, 0, 0, 8388607);
      send_fields(REQ_STEER, 2000, 0, 4000, 0, 0);
      send_fields(REQ_CHECK, 2000, 1, 4000, 1, 0);
      send_fields(REQ_STEER, 8388607, 8388607, -8388608, -8388608, 0);
   endtask

   function automatic int near_coord();
      return ($urandom_range(0, 4) == 0) ? int'($urandom()) : $urandom_range(0, 16384) - 8192;
   endfunction

   task automatic test_random_traffic();
      req_item_type it;
      int pick;
      for (int n = 0; n < 1480; n++) begin
         if (n % 60 == 0) no_idle = $urandom_range(0, 3) == 0;
         pick = $urandom_range(0, 99);
         it.ax = COORD_W'(near_coord());
         it.ay = COORD_W'(near_coord());
         it.bx = COORD_W'(near_coord());
         it.by = COORD_W'(near_coord());
         it.radius = ($urandom_range(0, 9) == 0) ? RAD_W'($urandom()) :
                     RAD_W'($urandom_range(0, 2048));
         if ((circ_count < MAX_OBSTACLES && pick < 30) || pick < 3) begin
            it.req_type = REQ_ADD;
         end else if (pick < 5) begin
            it.req_type = 2'd3;
         end else begin
            it.req_type = pick[0] ? REQ_STEER : REQ_CHECK;
            // short segments now and then
            if (pick < 10) begin
               it.bx = it.ax + COORD_W'($urandom_range(0, 512) - 256);
               it.by = it.ay + COORD_W'($urandom_range(0, 512) - 256);
            end
         end
         send_item(it);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      rsp_hold = 0;
      circ_count = 0;
      error_count = 0;
      no_idle = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_empty_table();
      test_unknown_type();
      test_circle_cases();
      test_random_traffic();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #600_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+sv
sv/scc_pkg.sv
sv/scc_mul.sv
sv/scc_datapath.sv
sv/scc_ctrl.sv
sv/segment_circle_steer_check.sv
sv/scc_checker.sv
dv/segment_circle_steer_check_test.sv
